@@ hdl/c8x_pkg.sv @@
// ----------------------------------------------------------------------------
// c8x_pkg
// shared types and constants for the chip8 instruction execute core
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [15:0] PC_RESET     = 16'h0200;
  localparam logic [15:0] HIRES_JUMP   = 16'h1260;
  localparam logic [15:0] HIRES_TARGET = 16'h12C0;

  localparam logic [1:0] ACT_EXEC = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_KEYS = 2'd2;

  localparam logic [1:0] RUN_GO   = 2'd0;
  localparam logic [1:0] RUN_WAIT = 2'd1;
  localparam logic [1:0] RUN_HALT = 2'd2;
  localparam logic [1:0] RUN_EXIT = 2'd3;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_UNDER = 2'd1;
  localparam logic [1:0] CAUSE_OVER  = 2'd2;
  localparam logic [1:0] CAUSE_UNIMP = 2'd3;

  localparam logic [2:0] DISP_NONE   = 3'd0;
  localparam logic [2:0] DISP_CLEAR  = 3'd1;
  localparam logic [2:0] DISP_SDOWN  = 3'd2;
  localparam logic [2:0] DISP_SLEFT  = 3'd3;
  localparam logic [2:0] DISP_DRAW   = 3'd4;

  // shared unit operations
  typedef enum logic [3:0] {
    OP_PASS, OP_OR, OP_AND, OP_XOR, OP_ADD, OP_SUB, OP_RSUB, OP_SHR, OP_SHL
  } alu_op_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       flag;
    logic       eq;
  } alu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_ALU, ST_LOOP, ST_BCD, ST_OUT
  } state_t;

  // loop kinds of the sequencer
  localparam logic [1:0] LOOP_STORE = 2'd0;
  localparam logic [1:0] LOOP_SAVE  = 2'd1;
  localparam logic [1:0] LOOP_LOAD  = 2'd2;

endpackage

@@ hdl/c8x_alu.sv @@
// ----------------------------------------------------------------------------
// c8x_alu
// shared 8-bit arithmetic, logic and shift unit
// ----------------------------------------------------------------------------
module c8x_alu
  import c8x_pkg::*;
(
  input  alu_op_t    op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output alu_res_t   res
);
  logic [8:0] add9;
  assign add9 = {1'b0, a} + {1'b0, b};

  always_comb begin
    res.eq   = (a == b);
    res.flag = 1'b0;
    res.sum  = b;
    unique case (op)
      OP_PASS: res.sum = b;
      OP_OR:   res.sum = a | b;
      OP_AND:  res.sum = a & b;
      OP_XOR:  res.sum = a ^ b;
      OP_ADD:  begin res.sum = add9[7:0]; res.flag = add9[8]; end
      OP_SUB:  begin res.sum = a - b; res.flag = (a >= b); end
      OP_RSUB: begin res.sum = b - a; res.flag = (b >= a); end
      OP_SHR:  begin res.sum = {1'b0, a[7:1]}; res.flag = a[0]; end
      OP_SHL:  begin res.sum = {a[6:0], 1'b0}; res.flag = a[7]; end
      default: res.sum = b;
    endcase
  end
endmodule

@@ hdl/chip8_instruction_execute_core.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_execute_core
// sequenced chip8/schip instruction executor with a shared 8-bit unit
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: tdata = {random_byte, keys, instruction}
//   (bits 15:0 instruction, 31:16 keys, 39:32 random_byte), tuser = action.
//   m_axis returns one or more results per request, tlast on the final one.
//   tdata = next_pc, mem_write, mem_addr, mem_data, run_state, halt_cause,
//   display_op, sound_start, sound_length, hires_mode, superhires_mode
//   from bit 0 up (64 bits, zero filled).
// sequencing:
//   a plain request passes from the exec to the out state before its result
//   is registered; 8xyN passes through the alu state first; Fx75/85 step
//   through the registers (up to 16); Fx55 emits one write per cycle while
//   m_tready holds (up to 16), the last write carrying tlast; Fx33 subtracts
//   100, then 10, repeatedly and writes the three digits, hundreds first.
//   one request in flight; s_tready is low while busy.
// reset:
//   pc 0x200, index, stack pointer, timer, keys, modes cleared; register
//   files are not cleared and are undefined until written.
// stall:
//   a held result stays in the output register until m_tready; the sequencer
//   waits to load its next result and accepts nothing new meanwhile.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_core
  import c8x_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // instruction, keys, random_byte
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // next_pc, mem_write, mem_addr, mem_data, run_state,
                                 // halt_cause, display_op, sound_start, sound_length,
                                 // hires_mode, superhires_mode
  output logic        m_tlast
);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  state_t state, state_next;

  // architectural state
  logic [7:0]  vreg [16];
  logic [7:0]  fstore [16];
  logic [15:0] stk [STACK_DEPTH];
  logic [15:0] index_reg, pc;
  logic [SPW-1:0] sp;
  logic [7:0]  dtimer;
  logic [15:0] key_bits;
  logic [1:0]  run_mode, cause;
  logic        hires, shires;
  logic [3:0]  wait_reg;

  // request capture
  logic [1:0]  act;
  logic [15:0] ins;
  logic [15:0] keys_in;
  logic [7:0]  rnd;

  // per-request result fields
  logic [2:0]  disp;
  logic        snd_go;
  logic [7:0]  snd_len;

  // sequencer work registers
  logic [3:0]  cnt;
  logic [1:0]  loop_kind;
  logic [7:0]  bval;
  logic [1:0]  bdig;
  logic [7:0]  bacc;

  // output register
  logic        ovalid, olast, owr;
  logic [15:0] oaddr;
  logic [7:0]  odata;

  logic [3:0] rx, ry;
  logic [7:0] kk;
  assign rx = ins[11:8];
  assign ry = ins[7:4];
  assign kk = ins[7:0];

  // shared unit
  alu_op_t  aop;
  logic [7:0] aa, ab;
  alu_res_t ares;
  c8x_alu u_alu (.op(aop), .a(aa), .b(ab), .res(ares));

  always_comb begin
    aop = OP_PASS;
    aa  = vreg[rx];
    ab  = vreg[ry];
    if (state == ST_BCD) begin
      aop = OP_SUB;
      aa  = bval;
      ab  = (bdig == 2'd0) ? 8'd100 : 8'd10;
    end else if (state == ST_ALU) begin
      unique case (ins[3:0])
        4'h1: aop = OP_OR;
        4'h2: aop = OP_AND;
        4'h3: aop = OP_XOR;
        4'h4: aop = OP_ADD;
        4'h5: aop = OP_SUB;
        4'h6: aop = OP_SHR;
        4'h7: aop = OP_RSUB;
        4'hE: aop = OP_SHL;
        default: aop = OP_PASS;
      endcase
    end else if (ins[15:12] == 4'h7) begin
      aop = OP_ADD;
      ab  = kk;
    end else if (ins[15:12] == 4'h3 || ins[15:12] == 4'h4) begin
      ab  = kk;
    end
  end

  logic out_free;
  assign out_free = !ovalid || m_tready;

  // a new request only once the previous final result is gone
  assign s_tready = (state == ST_IDLE) && out_free;
  assign m_tvalid = ovalid;
  assign m_tlast  = olast;
  assign m_tdata  = {5'd0, shires, hires, snd_len, snd_go, disp, cause, run_mode,
                     odata, oaddr, owr, pc};

  // output register gets loaded this cycle
  logic oload;
  assign oload = out_free &&
                 ((state == ST_LOOP && loop_kind == LOOP_STORE) ||
                  (state == ST_BCD && !(ares.flag && bdig != 2'd2)) ||
                  (state == ST_OUT));

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // stack helpers
  logic [SIW-1:0] sp_top, sp_dec;
  logic [SPW-1:0] sp_m1;
  assign sp_m1  = sp - SPW'(1);
  assign sp_top = sp[SIW-1:0];
  assign sp_dec = sp_m1[SIW-1:0];

  // lowest pressed key
  logic [3:0] low_key;
  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--)
      if (keys_in[k]) low_key = 4'(k);
  end

  logic key_down;
  assign key_down = (vreg[rx][7:4] == 4'd0) && key_bits[vreg[rx][3:0]];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid && out_free) state_next = ST_EXEC;
      ST_EXEC: begin
        if (act == ACT_EXEC && run_mode == RUN_GO && ins[15:12] == 4'h8 &&
            (ins[3:0] <= 4'h7 || ins[3:0] == 4'hE))
          state_next = ST_ALU;
        else if (act == ACT_EXEC && run_mode == RUN_GO && ins[15:12] == 4'hF &&
                 (kk == 8'h55 || kk == 8'h75 || kk == 8'h85))
          state_next = ST_LOOP;
        else if (act == ACT_EXEC && run_mode == RUN_GO && ins[15:12] == 4'hF &&
                 kk == 8'h33)
          state_next = ST_BCD;
        else
          state_next = ST_OUT;
      end
      ST_ALU: state_next = ST_OUT;
      ST_LOOP: begin
        // a store run ends on its last write, which carries tlast
        if (loop_kind == LOOP_STORE) begin
          if (out_free && cnt == rx) state_next = ST_IDLE;
        end else if (cnt == rx) state_next = ST_OUT;
      end
      ST_BCD: if (out_free && bdig == 2'd2) state_next = ST_IDLE;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_reg <= '0;
      pc        <= PC_RESET;
      sp        <= '0;
      dtimer    <= '0;
      key_bits  <= '0;
      run_mode  <= RUN_GO;
      cause     <= CAUSE_NONE;
      hires     <= 1'b0;
      shires    <= 1'b0;
      wait_reg  <= '0;
      ovalid    <= 1'b0;
      olast     <= 1'b0;
      disp      <= DISP_NONE;
      snd_go    <= 1'b0;
      snd_len   <= '0;
    end else begin
      if (oload)         ovalid <= 1'b1;
      else if (m_tready) ovalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_tvalid && out_free) begin
          act     <= s_tuser;
          ins     <= s_tdata[15:0];
          keys_in <= s_tdata[31:16];
          rnd     <= s_tdata[39:32];
          disp    <= DISP_NONE;
          snd_go  <= 1'b0;
          snd_len <= '0;
        end
        ST_EXEC: begin
          cnt  <= '0;
          bval <= vreg[rx];
          bdig <= 2'd0;
          bacc <= '0;
          unique case (kk)
            8'h55:   loop_kind <= LOOP_STORE;
            8'h75:   loop_kind <= LOOP_SAVE;
            default: loop_kind <= LOOP_LOAD;
          endcase
          if (act == ACT_TICK) begin
            if (dtimer != 8'd0) dtimer <= dtimer - 8'd1;
          end else if (act == ACT_KEYS) begin
            key_bits <= keys_in;
            if (run_mode == RUN_WAIT && keys_in != 16'd0) begin
              vreg[wait_reg] <= {4'd0, low_key};
              run_mode <= RUN_GO;
            end
          end else if (act == ACT_EXEC && run_mode == RUN_GO) begin
            logic [15:0] w, p2, p4, pc_n;
            w  = ins;
            if (pc == PC_RESET && ins == HIRES_JUMP) begin
              hires <= 1'b1;
              w = HIRES_TARGET;
              ins <= HIRES_TARGET;
            end
            p2 = pc + 16'd2;
            p4 = pc + 16'd4;
            pc_n = p2;
            unique case (w[15:12])
              4'h0: begin
                if (w[15:4] == 12'h00C) disp <= DISP_SDOWN;
                else if (w == 16'h00E0 || w == 16'h0230) disp <= DISP_CLEAR;
                else if (w == 16'h00EE) begin
                  if (sp == '0) begin run_mode <= RUN_HALT; cause <= CAUSE_UNDER; end
                  else begin sp <= sp_m1; pc_n = stk[sp_dec]; end
                end
                else if (w == 16'h00FC) disp <= DISP_SLEFT;
                else if (w == 16'h00FD) run_mode <= RUN_EXIT;
                else if (w == 16'h00FE) shires <= 1'b0;
                else if (w == 16'h00FF) shires <= 1'b1;
                else begin run_mode <= RUN_HALT; cause <= CAUSE_UNIMP; end
              end
              4'h1: pc_n = {4'd0, w[11:0]};
              4'h2: begin
                if (sp >= SPW'(STACK_DEPTH)) begin
                  run_mode <= RUN_HALT; cause <= CAUSE_OVER;
                end else begin
                  stk[sp_top] <= p2;
                  sp <= sp + SPW'(1);
                  pc_n = {4'd0, w[11:0]};
                end
              end
              4'h3: if (ares.eq)  pc_n = p4;
              4'h4: if (!ares.eq) pc_n = p4;
              4'h5: if (ares.eq)  pc_n = p4;
              4'h6: vreg[rx] <= kk;
              4'h7: vreg[rx] <= ares.sum;
              4'h8: if (!(w[3:0] <= 4'h7 || w[3:0] == 4'hE)) begin
                run_mode <= RUN_HALT; cause <= CAUSE_UNIMP;
              end
              4'h9: if (!ares.eq) pc_n = p4;
              4'hA: index_reg <= {4'd0, w[11:0]};
              4'hB: begin run_mode <= RUN_HALT; cause <= CAUSE_UNIMP; end
              4'hC: vreg[rx] <= rnd & kk;
              4'hD: disp <= DISP_DRAW;
              4'hE: begin
                if (kk == 8'h9E) begin if (key_down) pc_n = p4; end
                else if (kk == 8'hA1) begin if (!key_down) pc_n = p4; end
                else begin run_mode <= RUN_HALT; cause <= CAUSE_UNIMP; end
              end
              4'hF: begin
                unique case (kk)
                  8'h07: vreg[rx] <= dtimer;
                  8'h0A: begin run_mode <= RUN_WAIT; wait_reg <= rx; end
                  8'h15: dtimer <= vreg[rx];
                  8'h18: begin snd_go <= 1'b1; snd_len <= kk; end
                  8'h1E: index_reg <= index_reg + {8'd0, vreg[rx]};
                  8'h29: index_reg <= {8'd0, vreg[rx]} * 16'd5;
                  8'h30: index_reg <= {8'd0, vreg[rx]} * 16'd10;
                  8'h33, 8'h55, 8'h75, 8'h85: ;
                  default: begin run_mode <= RUN_HALT; cause <= CAUSE_UNIMP; end
                endcase
              end
              default: ;
            endcase
            pc <= pc_n;
          end
        end
        ST_ALU: begin
          // flag order: add writes vf last, shifts and subtracts write vf first, 8xy0-8xy3 leave vf
          if (ins[3:0] == 4'h4) begin
            if (rx != 4'hF) vreg[rx] <= ares.sum;
            vreg[15] <= {7'd0, ares.flag};
          end else if (ins[3:0] == 4'h0 || ins[3:0] == 4'h1 ||
                       ins[3:0] == 4'h2 || ins[3:0] == 4'h3) begin
            vreg[rx] <= ares.sum;
          end else begin
            if (rx != 4'hF) vreg[15] <= {7'd0, ares.flag};
            vreg[rx] <= ares.sum;
          end
        end
        ST_LOOP: begin
          if (loop_kind == LOOP_STORE) begin
            if (out_free) begin
              olast  <= (cnt == rx);
              owr    <= 1'b1;
              oaddr  <= index_reg + {12'd0, cnt};
              odata  <= vreg[cnt];
              cnt    <= cnt + 4'd1;
            end
          end else begin
            if (loop_kind == LOOP_SAVE) fstore[cnt] <= vreg[cnt];
            else                        vreg[cnt]   <= fstore[cnt];
            cnt <= cnt + 4'd1;
          end
        end
        ST_BCD: begin
          // repeated subtract of 100 or 10, one step per cycle
          if (ares.flag && bdig != 2'd2) begin
            bval <= ares.sum;
            bacc <= bacc + 8'd1;
          end else if (out_free) begin
            olast  <= (bdig == 2'd2);
            owr    <= 1'b1;
            oaddr  <= index_reg + {14'd0, bdig};
            odata  <= (bdig == 2'd2) ? bval : bacc;
            bdig   <= bdig + 2'd1;
            bacc   <= '0;
          end
        end
        ST_OUT: if (out_free) begin
          // single status result for requests without memory writes
          olast  <= 1'b1;
          owr    <= 1'b0;
          oaddr  <= '0;
          odata  <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ hdl/c8x_checker.sv @@
// ----------------------------------------------------------------------------
// c8x_checker
// port level checks of the execute core
// ----------------------------------------------------------------------------
module c8x_checker
  import c8x_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[16] |-> m_tlast)
    else $error("status result not marked last");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted two requests back to back");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[44:43] != CAUSE_NONE |-> m_tdata[42:41] == RUN_HALT)
    else $error("halt cause without halt");
endmodule

bind chip8_instruction_execute_core c8x_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast));

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the chip8 instruction execute core: requests are
// predicted at accept time by an in-bench executor model, results are checked
// field by field in order, with bursty input and a stalling result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import c8x_pkg::*;

  localparam int LIMIT = 500000;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // one result as the core reports it
  typedef struct packed {
    logic [15:0] pc;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  run;
    logic [1:0]  cause;
    logic [2:0]  disp;
    logic        sgo;
    logic [7:0]  slen;
    logic        hi;
    logic        shi;
    logic        last;
  } exec_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // instruction, keys, random_byte
  logic [1:0]  s_tuser = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // next_pc, mem_write, mem_addr, mem_data, run_state,
                               // halt_cause, display_op, sound_start, sound_length,
                               // hires_mode, superhires_mode
  logic        m_tlast;

  chip8_instruction_execute_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // executor state mirrored by the bench
  logic [7:0]  vreg [16];
  logic [7:0]  flagst [16];
  logic [15:0] stk [16];
  logic [15:0] idx, pc, keyb;
  int          sp;
  logic [7:0]  dtimer;
  logic [1:0]  mode, cause;
  logic        hires, shires;
  logic [3:0]  wreg;
  logic [2:0]  disp;
  logic        sgo;
  logic [7:0]  slen;

  exec_res_t   item_q [$];     // results of the request being predicted
  exec_res_t   pending_q [$];  // results still owed by the core
  int          errors = 0;
  int          cycles = 0;
  int          hold_cnt = 0;
  int          stall_pct = 0;

  task automatic report(input string msg);
    $display("error at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic add_res(input logic wr, input logic [15:0] addr, input logic [7:0] data);
    exec_res_t r;
    r.pc = pc; r.wr = wr; r.addr = wr ? addr : 16'h0; r.data = wr ? data : 8'h0;
    r.run = mode; r.cause = cause; r.disp = disp; r.sgo = sgo; r.slen = slen;
    r.hi = hires; r.shi = shires; r.last = 1'b0;
    if (item_q.size() < 16) item_q.push_back(r);
  endtask

  task automatic halt(input logic [1:0] c);
    mode = RUN_HALT;
    cause = c;
  endtask

  // executes one request on the mirrored state and queues its results
  task automatic predict_exec(input logic [1:0] act, input logic [15:0] w_in,
                              input logic [15:0] keys, input logic [7:0] rnd);
    logic [15:0] w, nnn;
    logic [3:0]  x, y;
    logic [7:0]  kk, a, b;
    logic        down;
    int          k;
    w = w_in; x = w[11:8]; y = w[7:4]; kk = w[7:0]; nnn = {4'h0, w[11:0]};
    item_q.delete();
    disp = DISP_NONE; sgo = 1'b0; slen = 8'h0;
    if (act == ACT_EXEC && mode == RUN_GO) begin
      // start quirk: a jump to 0x260 at 0x200 means hires, redirected to 0x2C0
      if (pc == PC_RESET && w == HIRES_JUMP) begin
        hires = 1'b1; w = HIRES_TARGET; nnn = 16'h02C0;
      end
      pc = pc + 16'd2;
      a = vreg[x]; b = vreg[y];
      case (w[15:12])
        4'h0: begin
          if (w[15:4] == 12'h00C) disp = DISP_SDOWN;
          else case (w)
            16'h00E0, 16'h0230: disp = DISP_CLEAR;
            16'h00EE: begin
              if (sp == 0) halt(CAUSE_UNDER);
              else begin sp--; pc = stk[sp]; end
            end
            16'h00FC: disp = DISP_SLEFT;
            16'h00FD: mode = RUN_EXIT;
            16'h00FE: shires = 1'b0;
            16'h00FF: shires = 1'b1;
            default: halt(CAUSE_UNIMP);
          endcase
        end
        4'h1: pc = nnn;
        4'h2: begin
          if (sp >= 16) halt(CAUSE_OVER);
          else begin stk[sp] = pc; sp++; pc = nnn; end
        end
        4'h3: if (a == kk) pc = pc + 16'd2;
        4'h4: if (a != kk) pc = pc + 16'd2;
        4'h5: if (a == b) pc = pc + 16'd2;
        4'h6: vreg[x] = kk;
        4'h7: vreg[x] = a + kk;
        4'h8: begin
          // vf written after vx only for the add
          case (w[3:0])
            4'h0: vreg[x] = b;
            4'h1: vreg[x] = a | b;
            4'h2: vreg[x] = a & b;
            4'h3: vreg[x] = a ^ b;
            4'h4: begin vreg[x] = a + b; vreg[15] = ({1'b0, a} + {1'b0, b} > 9'hFF); end
            4'h5: begin vreg[15] = (a >= b); vreg[x] = a - b; end
            4'h6: begin vreg[15] = a[0]; vreg[x] = a >> 1; end
            4'h7: begin vreg[15] = (b >= a); vreg[x] = b - a; end
            4'hE: begin vreg[15] = a[7]; vreg[x] = a << 1; end
            default: halt(CAUSE_UNIMP);
          endcase
        end
        4'h9: if (a != b) pc = pc + 16'd2;
        4'hA: idx = nnn;
        4'hB: halt(CAUSE_UNIMP);
        4'hC: vreg[x] = rnd & kk;
        4'hD: disp = DISP_DRAW;
        4'hE: begin
          down = (a < 8'd16) && keyb[a[3:0]];
          if (kk == 8'h9E) begin if (down) pc = pc + 16'd2; end
          else if (kk == 8'hA1) begin if (!down) pc = pc + 16'd2; end
          else halt(CAUSE_UNIMP);
        end
        default: begin
          case (kk)
            8'h07: vreg[x] = dtimer;
            8'h0A: begin mode = RUN_WAIT; wreg = x; end
            8'h15: dtimer = a;
            8'h18: begin sgo = 1'b1; slen = kk; end
            8'h1E: idx = idx + {8'h0, a};
            8'h29: idx = 16'd5 * a;
            8'h30: idx = 16'd10 * a;
            8'h33: begin
              add_res(1'b1, idx, a / 8'd100);
              add_res(1'b1, idx + 16'd1, (a / 8'd10) % 8'd10);
              add_res(1'b1, idx + 16'd2, a % 8'd10);
            end
            8'h55: for (int i = 0; i <= x; i++) add_res(1'b1, idx + 16'(i), vreg[i]);
            8'h75: for (int i = 0; i <= x; i++) flagst[i] = vreg[i];
            8'h85: for (int i = 0; i <= x; i++) vreg[i] = flagst[i];
            default: halt(CAUSE_UNIMP);
          endcase
        end
      endcase
    end else if (act == ACT_TICK) begin
      if (dtimer > 0) dtimer--;
    end else if (act == ACT_KEYS) begin
      keyb = keys;
      if (mode == RUN_WAIT && keys != 16'h0) begin
        for (k = 0; k < 16; k++) if (keys[k]) break;
        vreg[wreg] = k[7:0];
        mode = RUN_GO;
      end
    end
    if (item_q.size() == 0) add_res(1'b0, 16'h0, 8'h0);
    item_q[item_q.size() - 1].last = 1'b1;
    foreach (item_q[i]) pending_q.push_back(item_q[i]);
  endtask

  // offers one request and holds it until taken; valid stays high afterwards
  task automatic send(input logic [1:0] act, input logic [15:0] w,
                      input logic [15:0] keys = 16'h0, input logic [7:0] rnd = 8'h0);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {rnd, keys, w};
    do @(posedge clk); while (!s_tready);
    predict_exec(act, w, keys, rnd);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // picks a legal instruction that keeps the core running
  function automatic logic [15:0] pick_instr();
    logic [15:0] w;
    logic [7:0]  fops [11];
    logic [15:0] sys [7];
    fops = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h30, 8'h33, 8'h55, 8'h75, 8'h85};
    sys  = '{16'h00E0, 16'h0230, 16'h00C0, 16'h00FC, 16'h00FE, 16'h00FF, 16'h00EE};
    w = 16'($urandom);
    case (w[15:12])
      4'h0: begin
        w = sys[$urandom_range(0, sp > 0 ? 6 : 5)];
        if (w == 16'h00C0) w[3:0] = 4'($urandom);
      end
      4'h2: if (sp >= 16) w[15:12] = 4'h1;
      4'h8: begin
        w[3:0] = 4'($urandom_range(0, 8));
        if (w[3:0] == 4'h8) w[3:0] = 4'hE;
      end
      4'hB: w[15:12] = 4'h6;
      4'hE: w[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
      4'hF: w[7:0] = fops[$urandom_range(0, 10)];
      default: ;
    endcase
    return w;
  endfunction

  // result side: check against the oldest expectation, then pick next ready
  always @(posedge clk) begin
    exec_res_t e, g;
    if (!rst && m_tvalid && m_tready) begin
      g = {m_tdata[15:0], m_tdata[16], m_tdata[32:17], m_tdata[40:33], m_tdata[42:41],
           m_tdata[44:43], m_tdata[47:45], m_tdata[48], m_tdata[56:49], m_tdata[57],
           m_tdata[58], m_tlast};
      if (pending_q.size() == 0) report("result with no request owing one");
      else begin
        e = pending_q.pop_front();
        if (g.pc != e.pc) report($sformatf("next_pc %h, want %h", g.pc, e.pc));
        if (g.wr != e.wr) report($sformatf("mem_write %b, want %b", g.wr, e.wr));
        if (g.addr != e.addr) report($sformatf("mem_addr %h, want %h", g.addr, e.addr));
        if (g.data != e.data) report($sformatf("mem_data %h, want %h", g.data, e.data));
        if (g.run != e.run) report($sformatf("run_state %0d, want %0d", g.run, e.run));
        if (g.cause != e.cause) report($sformatf("halt_cause %0d, want %0d", g.cause, e.cause));
        if (g.disp != e.disp) report($sformatf("display_op %0d, want %0d", g.disp, e.disp));
        if (g.sgo != e.sgo) report($sformatf("sound_start %b, want %b", g.sgo, e.sgo));
        if (g.slen != e.slen) report($sformatf("sound_length %h, want %h", g.slen, e.slen));
        if (g.hi != e.hi) report($sformatf("hires_mode %b, want %b", g.hi, e.hi));
        if (g.shi != e.shi) report($sformatf("superhires_mode %b, want %b", g.shi, e.shi));
        if (g.last != e.last) report($sformatf("tlast %b, want %b", g.last, e.last));
      end
    end
    // stall level is redrawn from 0, 35 or 70 percent; a long hold-off overrides it
    if (cycles % 64 == 0) stall_pct = $urandom_range(0, 2) * 35;
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // hires start quirk, then every register and flag byte gets written
  task automatic test_start();
    send(ACT_EXEC, HIRES_JUMP);
    for (int i = 0; i < 16; i++) begin
      send(ACT_EXEC, {4'h6, 4'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom)});
    end
    send(ACT_EXEC, 16'hFF75);
    wait_drained();
  endtask

  // alu group with vf as destination and carry / borrow corner values
  task automatic test_alu();
    send(ACT_EXEC, 16'h6FFF);
    send(ACT_EXEC, 16'h8F14);  // vf = ff + ff, carry written last
    send(ACT_EXEC, 16'h6F00);
    send(ACT_EXEC, 16'h8F15);  // 0 - ff, vx result wins
    send(ACT_EXEC, 16'h8F16);
    send(ACT_EXEC, 16'h6F80);
    send(ACT_EXEC, 16'h8F0E);
    send(ACT_EXEC, 16'h8107);
    pause($urandom_range(0, 3));
  endtask

  // memory writes, key wait, key tests, timer, display and sound
  task automatic test_misc();
    send(ACT_EXEC, 16'hAFFF);
    send(ACT_EXEC, 16'hF133);  // bcd of 1
    send(ACT_EXEC, 16'hFF55);  // sixteen writes
    send(ACT_EXEC, 16'hF385);
    send(ACT_EXEC, 16'hF50A);
    send(ACT_EXEC, 16'h6012);  // ignored while waiting
    send(ACT_KEYS, 16'h0, 16'h0000);
    send(ACT_KEYS, 16'h0, 16'h8000);  // releases, v5 = 15
    send(ACT_EXEC, 16'h6A40);
    send(ACT_EXEC, 16'hEA9E);  // key number out of range
    send(ACT_EXEC, 16'hEAA1);
    send(ACT_EXEC, 16'hF515);
    send(ACT_TICK, 16'h0);
    send(ACT_EXEC, 16'hF707);
    send(ACT_SPARE, 16'hFFFF, 16'hFFFF, 8'd254);  // unused action code
    send(ACT_EXEC, 16'h00FF);
    send(ACT_EXEC, 16'hD123);
    send(ACT_EXEC, 16'h00CF);
    send(ACT_EXEC, 16'h00FC);
    send(ACT_EXEC, 16'h00E0);
    send(ACT_EXEC, 16'hF0FF & 16'hF018 | 16'h00FF & 16'h0018);
    send(ACT_EXEC, 16'h00FE);
    send(ACT_EXEC, 16'hCAFF, 16'h0, 8'd254);
    wait_drained();
  endtask

  // bursts of random requests with random gaps
  task automatic test_random(input int count);
    int n = 0;
    int burst;
    logic [1:0] act;
    while (n < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n < count; i++) begin
        case ($urandom_range(0, 19))
          0, 1:    act = ACT_TICK;
          2, 3, 4: act = ACT_KEYS;
          5:       act = ACT_SPARE;
          default: act = ACT_EXEC;
        endcase
        send(act, pick_instr(), $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom),
             8'($urandom_range(0, 254)));
        n++;
      end
      pause($urandom_range(0, 6));
    end
  endtask

  // result side held off while requests keep coming, then a full drain
  task automatic test_backpressure();
    hold_cnt = 300;
    send(ACT_EXEC, 16'hFF55);
    for (int i = 0; i < 6; i++) send(ACT_EXEC, pick_instr(), 16'h0, 8'($urandom_range(0, 254)));
    wait_drained();
  endtask

  // one way of stopping the core, then requests against a stopped core
  task automatic test_stop();
    // a pending key wait would block the stack runs below
    if (mode == RUN_WAIT) send(ACT_KEYS, 16'h0, 16'h0001);
    case ($urandom_range(0, 3))
      0: begin
        while (sp > 0) send(ACT_EXEC, 16'h00EE);
        send(ACT_EXEC, 16'h00EE);
      end
      1: begin
        while (sp < 16) send(ACT_EXEC, {4'h2, 12'($urandom)});
        send(ACT_EXEC, 16'h2ABC);
      end
      2: send(ACT_EXEC, 16'hB123);
      default: send(ACT_EXEC, 16'h00FD);
    endcase
    send(ACT_EXEC, 16'h6055);
    send(ACT_TICK, 16'h0);
    send(ACT_KEYS, 16'h0, 16'h0001);
    send(ACT_SPARE, 16'h0);
    wait_drained();
  endtask

  initial begin
    foreach (vreg[i]) begin vreg[i] = 8'h0; flagst[i] = 8'h0; stk[i] = 16'h0; end
    idx = 16'h0; pc = PC_RESET; keyb = 16'h0; sp = 0; dtimer = 8'h0;
    mode = RUN_GO; cause = CAUSE_NONE; hires = 1'b0; shires = 1'b0; wreg = 4'h0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_start();
    test_alu();
    test_misc();
    test_random(22);
    test_backpressure();
    test_random(22);
    wait_drained();
    test_stop();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
